// File: hw/rtl/locally_connected_layer_2d_macros.svh
// Assertion macros shared by the checkers of the locally connected layer.
// No dependencies; the including module supplies clock and reset.
`ifndef LOCALLY_CONNECTED_LAYER_2D_MACROS_SVH
`define LOCALLY_CONNECTED_LAYER_2D_MACROS_SVH

// Check on every clock edge outside reset.
`define LCL2D_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every clock edge, reset included.
`define LCL2D_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hw/rtl/lcl2d_pkg.sv
// Shared types and constants of the locally connected layer.
// No dependencies; the CSR, controller, datapath and top level refer to it by scoped names.
`timescale 1ns / 1ps

package lcl2d_pkg;

   localparam int VAL_W    = 16;
   localparam int PROD_W   = 32;
   localparam int ACC_W    = 48;
   localparam int SUM_W    = 40;
   localparam int POS_GRID = 16;

   typedef enum logic [1:0] {
      REQ_SAMPLE  = 2'd0,
      REQ_WEIGHT  = 2'd1,
      REQ_COMPUTE = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [4:0] out_height;
      logic [4:0] out_width;
      logic       pad_rows;
      logic       pad_cols;
      logic [2:0] stride_rows;
      logic [2:0] stride_cols;
      logic       xcorr_mode;
   } cfg_type;

   typedef struct packed {
      logic wr_img;
      logic wr_wgt;
      logic start;
      logic issue;
      logic latch;
      logic emit_adv;
   } cmd_type;

   typedef struct packed {
      logic pos_ok;
      logic tap_last;
      logic pipe_busy;
      logic chan_last;
   } sts_type;

endpackage

// File: hw/rtl/lcl2d_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module lcl2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/lcl2d_csr.sv
// Configuration registers of the locally connected layer behind an APB-style port.
// Depends on lcl2d_pkg for the configuration struct.
`timescale 1ns / 1ps

module lcl2d_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [4:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output lcl2d_pkg::cfg_type   cfg
);

   localparam logic [2:0] REG_OUT_HEIGHT  = 3'd0;
   localparam logic [2:0] REG_OUT_WIDTH   = 3'd1;
   localparam logic [2:0] REG_PAD_ROWS    = 3'd2;
   localparam logic [2:0] REG_PAD_COLS    = 3'd3;
   localparam logic [2:0] REG_STRIDE_ROWS = 3'd4;
   localparam logic [2:0] REG_STRIDE_COLS = 3'd5;
   localparam logic [2:0] REG_XCORR_MODE  = 3'd6;

   lcl2d_pkg::cfg_type cfg_ff;
   lcl2d_pkg::cfg_type cfg_in;
   logic [2:0]         reg_idx;
   logic               wr_stb;

   assign reg_idx = paddr[4:2];
   assign wr_stb  = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         unique case (reg_idx)
            REG_OUT_HEIGHT:  cfg_in.out_height  = pwdata[4:0];
            REG_OUT_WIDTH:   cfg_in.out_width   = pwdata[4:0];
            REG_PAD_ROWS:    cfg_in.pad_rows    = pwdata[0];
            REG_PAD_COLS:    cfg_in.pad_cols    = pwdata[0];
            REG_STRIDE_ROWS: cfg_in.stride_rows = pwdata[2:0];
            REG_STRIDE_COLS: cfg_in.stride_cols = pwdata[2:0];
            REG_XCORR_MODE:  cfg_in.xcorr_mode  = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.out_height  <= 5'd16;
         cfg_ff.out_width   <= 5'd16;
         cfg_ff.pad_rows    <= 1'b1;
         cfg_ff.pad_cols    <= 1'b1;
         cfg_ff.stride_rows <= 3'd1;
         cfg_ff.stride_cols <= 3'd1;
         cfg_ff.xcorr_mode  <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_OUT_HEIGHT:  prdata = 32'(cfg_ff.out_height);
         REG_OUT_WIDTH:   prdata = 32'(cfg_ff.out_width);
         REG_PAD_ROWS:    prdata = 32'(cfg_ff.pad_rows);
         REG_PAD_COLS:    prdata = 32'(cfg_ff.pad_cols);
         REG_STRIDE_ROWS: prdata = 32'(cfg_ff.stride_rows);
         REG_STRIDE_COLS: prdata = 32'(cfg_ff.stride_cols);
         REG_XCORR_MODE:  prdata = 32'(cfg_ff.xcorr_mode);
         default:         prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/lcl2d_ctrl.sv
// Controller state machine of the locally connected layer: handshakes and datapath commands.
// Depends on lcl2d_pkg for the state, request, command and status types.
`timescale 1ns / 1ps

module lcl2d_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_req_type,
   input  logic                 rsp_ready,
   input  lcl2d_pkg::sts_type   sts,
   output logic                 req_ready,
   output logic                 rsp_valid,
   output lcl2d_pkg::cmd_type   cmd
);

   lcl2d_pkg::state_type state_ff;
   lcl2d_pkg::state_type state_in;
   logic                 is_compute;

   assign is_compute = (req_req_type == lcl2d_pkg::REQ_COMPUTE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcl2d_pkg::ST_IDLE: begin
            if (req_valid && is_compute && sts.pos_ok) begin
               state_in = lcl2d_pkg::ST_RUN;
            end
         end
         lcl2d_pkg::ST_RUN: begin
            if (sts.tap_last) begin
               state_in = lcl2d_pkg::ST_DRAIN;
            end
         end
         lcl2d_pkg::ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = lcl2d_pkg::ST_EMIT;
            end
         end
         lcl2d_pkg::ST_EMIT: begin
            if (rsp_ready && sts.chan_last) begin
               state_in = lcl2d_pkg::ST_IDLE;
            end
         end
         default: state_in = lcl2d_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcl2d_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         lcl2d_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.wr_img = req_valid && (req_req_type == lcl2d_pkg::REQ_SAMPLE);
            cmd.wr_wgt = req_valid && (req_req_type == lcl2d_pkg::REQ_WEIGHT);
            cmd.start  = req_valid && is_compute;
         end
         lcl2d_pkg::ST_RUN: begin
            cmd.issue = 1'b1;
         end
         lcl2d_pkg::ST_DRAIN: begin
            cmd.latch = !sts.pipe_busy;
         end
         lcl2d_pkg::ST_EMIT: begin
            rsp_valid    = 1'b1;
            cmd.emit_adv = rsp_ready;
         end
         default: ;
      endcase
   end

endmodule

// File: hw/rtl/lcl2d_dp.sv
// Datapath of the locally connected layer: sample and weight stores, tap walk, MAC lanes.
// Depends on lcl2d_pkg and lcl2d_ram.
`timescale 1ns / 1ps

module lcl2d_dp #(
   parameter int IN_CHANNELS  = 4,
   parameter int IN_HEIGHT    = 16,
   parameter int IN_WIDTH     = 16,
   parameter int OUT_CHANNELS = 4,
   parameter int FILT_HEIGHT  = 3,
   parameter int FILT_WIDTH   = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lcl2d_pkg::cfg_type   cfg,
   input  lcl2d_pkg::cmd_type   cmd,
   output lcl2d_pkg::sts_type   sts,
   input  logic [1:0]           req_chan,
   input  logic [3:0]           req_row,
   input  logic [3:0]           req_col,
   input  logic [5:0]           req_tap,
   input  logic [1:0]           req_out_chan,
   input  logic signed [15:0]   req_value,
   output logic [1:0]           rsp_res_chan,
   output logic [3:0]           rsp_res_row,
   output logic [3:0]           rsp_res_col,
   output logic signed [39:0]   rsp_sum,
   output logic                 rsp_last
);

   localparam int VAL_W     = lcl2d_pkg::VAL_W;
   localparam int PROD_W    = lcl2d_pkg::PROD_W;
   localparam int ACC_W     = lcl2d_pkg::ACC_W;
   localparam int SUM_W     = lcl2d_pkg::SUM_W;
   localparam int NUM_TAPS  = IN_CHANNELS * FILT_HEIGHT * FILT_WIDTH;
   localparam int IMG_DEPTH = IN_CHANNELS * IN_HEIGHT * IN_WIDTH;
   localparam int WGT_DEPTH = lcl2d_pkg::POS_GRID * lcl2d_pkg::POS_GRID * NUM_TAPS;
   localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
   localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
   localparam int TW        = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
   localparam int CW        = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
   localparam int KRW       = (FILT_HEIGHT > 1) ? $clog2(FILT_HEIGHT) : 1;
   localparam int KCW       = (FILT_WIDTH > 1) ? $clog2(FILT_WIDTH) : 1;
   localparam int KW        = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;

   localparam logic signed [8:0] IH_S = 9'(IN_HEIGHT);
   localparam logic signed [8:0] IW_S = 9'(IN_WIDTH);
   localparam logic signed [ACC_W-1:0] SAT_MAX =
      {{(ACC_W - SUM_W + 1){1'b0}}, {(SUM_W - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

   // position registers, loaded when a compute word is taken
   logic [3:0]              row_ff, col_ff;
   logic signed [8:0]       base_r_ff, base_c_ff, base_r_in, base_c_in;
   logic [WGT_AW-1:0]       pos_base_ff, pos_base_in;

   // tap walk
   logic [TW-1:0]           t_ff, t_in;
   logic [CW-1:0]           c_ff, c_in;
   logic [KRW-1:0]          kr_ff, kr_in;
   logic [KCW-1:0]          kc_ff, kc_in;
   logic [KW-1:0]           k_ff, k_in;

   logic signed [8:0]       kr_off, kc_off, ir, ic;
   logic                    ir_ok, ic_ok;
   logic [IMG_AW-1:0]       img_wr_addr, img_rd_addr;
   logic [WGT_AW-1:0]       wgt_wr_addr, wgt_rd_addr;
   logic                    img_wr_ok, wgt_wr_ok;
   logic [VAL_W-1:0]        img_rd;
   logic [VAL_W-1:0]        wgt_rd [OUT_CHANNELS];

   // pipeline
   logic                    rd_vld_ff, rd_ok_ff, prod_vld_ff;
   logic signed [VAL_W-1:0] samp;
   logic signed [PROD_W-1:0] prod_ff [OUT_CHANNELS];
   logic signed [ACC_W-1:0] acc_ff [OUT_CHANNELS];
   logic signed [SUM_W-1:0] sat_in [OUT_CHANNELS];
   logic signed [SUM_W-1:0] sum_ff [OUT_CHANNELS];

   // ---------------- write side ----------------
   assign img_wr_ok = cmd.wr_img && (32'(req_chan) < IN_CHANNELS)
                      && (32'(req_row) < IN_HEIGHT) && (32'(req_col) < IN_WIDTH);
   assign wgt_wr_ok = cmd.wr_wgt && (32'(req_tap) < NUM_TAPS)
                      && (32'(req_out_chan) < OUT_CHANNELS);
   assign img_wr_addr = IMG_AW'((32'(req_chan) * IN_HEIGHT + 32'(req_row)) * IN_WIDTH
                                + 32'(req_col));
   assign pos_base_in = WGT_AW'((32'(req_row) * lcl2d_pkg::POS_GRID + 32'(req_col))
                                * NUM_TAPS);
   assign wgt_wr_addr = pos_base_in + WGT_AW'(req_tap);

   // ---------------- position setup ----------------
   assign base_r_in = $signed({2'b00, 7'(req_row) * 7'(cfg.stride_rows)})
                      - $signed({8'd0, cfg.pad_rows});
   assign base_c_in = $signed({2'b00, 7'(req_col) * 7'(cfg.stride_cols)})
                      - $signed({8'd0, cfg.pad_cols});

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         row_ff      <= req_row;
         col_ff      <= req_col;
         base_r_ff   <= base_r_in;
         base_c_ff   <= base_c_in;
         pos_base_ff <= pos_base_in;
      end
   end

   // ---------------- tap counters ----------------
   always_comb begin
      t_in  = t_ff;
      c_in  = c_ff;
      kr_in = kr_ff;
      kc_in = kc_ff;
      if (cmd.start) begin
         t_in  = '0;
         c_in  = '0;
         kr_in = '0;
         kc_in = '0;
      end else if (cmd.issue) begin
         t_in = t_ff + 1'b1;
         if (kc_ff == KCW'(FILT_WIDTH - 1)) begin
            kc_in = '0;
            if (kr_ff == KRW'(FILT_HEIGHT - 1)) begin
               kr_in = '0;
               c_in  = c_ff + 1'b1;
            end else begin
               kr_in = kr_ff + 1'b1;
            end
         end else begin
            kc_in = kc_ff + 1'b1;
         end
      end
   end

   always_comb begin
      k_in = k_ff;
      if (cmd.latch) begin
         k_in = '0;
      end else if (cmd.emit_adv) begin
         k_in = k_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff  <= '0;
         c_ff  <= '0;
         kr_ff <= '0;
         kc_ff <= '0;
         k_ff  <= '0;
      end else begin
         t_ff  <= t_in;
         c_ff  <= c_in;
         kr_ff <= kr_in;
         kc_ff <= kc_in;
         k_ff  <= k_in;
      end
   end

   // ---------------- read address ----------------
   // flip the tap in convolution mode
   assign kr_off = cfg.xcorr_mode ? $signed(9'(kr_ff))
                                  : $signed(9'(FILT_HEIGHT - 1) - 9'(kr_ff));
   assign kc_off = cfg.xcorr_mode ? $signed(9'(kc_ff))
                                  : $signed(9'(FILT_WIDTH - 1) - 9'(kc_ff));
   assign ir     = base_r_ff + kr_off;
   assign ic     = base_c_ff + kc_off;
   assign ir_ok  = !ir[8] && (ir < IH_S);
   assign ic_ok  = !ic[8] && (ic < IW_S);

   assign img_rd_addr = IMG_AW'((32'(c_ff) * IN_HEIGHT + 32'(ir[7:0])) * IN_WIDTH
                                + 32'(ic[7:0]));
   assign wgt_rd_addr = pos_base_ff + WGT_AW'(t_ff);

   lcl2d_ram #(
      .WIDTH (VAL_W),
      .DEPTH (IMG_DEPTH)
   ) u_img (
      .clock   (clock),
      .wr_en   (img_wr_ok),
      .wr_addr (img_wr_addr),
      .wr_data (req_value),
      .rd_en   (cmd.issue),
      .rd_addr (img_rd_addr),
      .rd_data (img_rd)
   );

   // one weight RAM per output channel, read side by side
   for (genvar k = 0; k < OUT_CHANNELS; k++) begin : g_lane
      lcl2d_ram #(
         .WIDTH (VAL_W),
         .DEPTH (WGT_DEPTH)
      ) u_wgt (
         .clock   (clock),
         .wr_en   (wgt_wr_ok && (32'(req_out_chan) == k)),
         .wr_addr (wgt_wr_addr),
         .wr_data (req_value),
         .rd_en   (cmd.issue),
         .rd_addr (wgt_rd_addr),
         .rd_data (wgt_rd[k])
      );
   end

   // ---------------- MAC pipeline ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= cmd.issue;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_ok_ff <= ir_ok && ic_ok;
      end
   end

   // outside the image reads as zero
   assign samp = rd_ok_ff ? $signed(img_rd) : '0;

   always_ff @(posedge clock) begin
      for (int k = 0; k < OUT_CHANNELS; k++) begin
         if (rd_vld_ff) begin
            prod_ff[k] <= samp * $signed(wgt_rd[k]);
         end
         if (cmd.start) begin
            acc_ff[k] <= '0;
         end else if (prod_vld_ff) begin
            acc_ff[k] <= acc_ff[k] + ACC_W'(prod_ff[k]);
         end
         if (cmd.latch) begin
            sum_ff[k] <= sat_in[k];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < OUT_CHANNELS; k++) begin
         if (acc_ff[k] > SAT_MAX) begin
            sat_in[k] = SUM_W'(SAT_MAX);
         end else if (acc_ff[k] < SAT_MIN) begin
            sat_in[k] = SUM_W'(SAT_MIN);
         end else begin
            sat_in[k] = acc_ff[k][SUM_W-1:0];
         end
      end
   end

   // ---------------- status and result ----------------
   assign sts.pos_ok    = ({1'b0, req_row} < cfg.out_height)
                          && ({1'b0, req_col} < cfg.out_width);
   assign sts.tap_last  = (t_ff == TW'(NUM_TAPS - 1));
   assign sts.pipe_busy = rd_vld_ff || prod_vld_ff;
   assign sts.chan_last = (k_ff == KW'(OUT_CHANNELS - 1));

   assign rsp_res_chan = 2'(k_ff);
   assign rsp_res_row  = row_ff;
   assign rsp_res_col  = col_ff;
   assign rsp_sum      = sum_ff[k_ff];
   assign rsp_last     = sts.chan_last;

endmodule

// File: hw/rtl/locally_connected_layer_2d.sv
// Locally connected 2D layer, top level: controller, datapath and configuration registers.
// Depends on lcl2d_pkg, lcl2d_csr, lcl2d_ctrl, lcl2d_dp and lcl2d_ram.
// Sample and weight writes finish in IDLE; a compute word walks one tap per cycle over
// NUM_TAPS = IN_CHANNELS*FILT_HEIGHT*FILT_WIDTH taps (36 by default), then hands out one
// sum per output channel, one per cycle while rsp_ready is high; the next word is taken
// only after the last channel's sum has been accepted.
// Synchronous active-high reset returns to idle and loads register defaults; stores keep data.
`timescale 1ns / 1ps

module locally_connected_layer_2d #(
   parameter int IN_CHANNELS  = 4,
   parameter int IN_HEIGHT    = 16,
   parameter int IN_WIDTH     = 16,
   parameter int OUT_CHANNELS = 4,
   parameter int FILT_HEIGHT  = 3,
   parameter int FILT_WIDTH   = 3
) (
   input  logic                clock,
   input  logic                reset,

   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_req_type,
   input  logic [1:0]          req_chan,
   input  logic [3:0]          req_row,
   input  logic [3:0]          req_col,
   input  logic [5:0]          req_tap,
   input  logic [1:0]          req_out_chan,
   input  logic signed [15:0]  req_value,

   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_res_chan,
   output logic [3:0]          rsp_res_row,
   output logic [3:0]          rsp_res_col,
   output logic signed [39:0]  rsp_sum,
   output logic                rsp_last,

   // configuration port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   // Flow of one compute word:
   //   IDLE  take the word, latch position, clear the per-channel accumulators
   //   RUN   issue one tap a cycle: sample RAM and all weight lanes read together
   //   DRAIN let the read and multiply stages empty, then saturate into the sum registers
   //   EMIT  hand out one word per output channel, last flagged on the final one
   // Write words and compute words for positions outside the active grid finish in IDLE.

   lcl2d_pkg::cfg_type cfg;
   lcl2d_pkg::cmd_type cmd;
   lcl2d_pkg::sts_type sts;

   lcl2d_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lcl2d_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_req_type (req_req_type),
      .rsp_ready    (rsp_ready),
      .sts          (sts),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .cmd          (cmd)
   );

   lcl2d_dp #(
      .IN_CHANNELS  (IN_CHANNELS),
      .IN_HEIGHT    (IN_HEIGHT),
      .IN_WIDTH     (IN_WIDTH),
      .OUT_CHANNELS (OUT_CHANNELS),
      .FILT_HEIGHT  (FILT_HEIGHT),
      .FILT_WIDTH   (FILT_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cmd          (cmd),
      .sts          (sts),
      .req_chan     (req_chan),
      .req_row      (req_row),
      .req_col      (req_col),
      .req_tap      (req_tap),
      .req_out_chan (req_out_chan),
      .req_value    (req_value),
      .rsp_res_chan (rsp_res_chan),
      .rsp_res_row  (rsp_res_row),
      .rsp_res_col  (rsp_res_col),
      .rsp_sum      (rsp_sum),
      .rsp_last     (rsp_last)
   );

endmodule

// File: hw/rtl/lcl2d_chk.sv
// Port-level checker for the locally connected layer, bound to the top level.
// Depends on locally_connected_layer_2d_macros.svh.
`timescale 1ns / 1ps
`include "locally_connected_layer_2d_macros.svh"

module lcl2d_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_res_chan,
   input logic [3:0]         rsp_res_row,
   input logic signed [39:0] rsp_sum,
   input logic               rsp_last
);

   `LCL2D_ASSERT_RST(a_reset_idle, reset |=> (!rsp_valid && req_ready), "not idle after reset")
   `LCL2D_ASSERT_CLK(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sum) && $stable(rsp_res_chan)), "stalled response word changed")
   `LCL2D_ASSERT_CLK(a_no_req_in_emit, rsp_valid |-> !req_ready, "request taken while sums pending")
   `LCL2D_ASSERT_CLK(a_chan_step, (rsp_valid && rsp_ready && !rsp_last) |=> (rsp_valid && (rsp_res_chan == 2'($past(rsp_res_chan) + 2'd1)) && $stable(rsp_res_row)), "output channels out of order")
   `LCL2D_ASSERT_CLK(a_last_ends, (rsp_valid && rsp_ready && rsp_last) |=> !rsp_valid, "response after last word")

endmodule

bind locally_connected_layer_2d lcl2d_chk u_chk (.*);
